// ----- rtl/core/plcm_pkg.sv -----
package plcm_pkg;

  localparam int PTS_MAX = 8;
  localparam int CFG_REGS = 7;
  localparam int PT_W = 40;
  localparam int ANG_W = 16;
  localparam int POS_W = 24;
  localparam int QBITS = 25;
  localparam int IDX_W = 3;

  typedef logic [PTS_MAX-1:0][PT_W-1:0] plcm_pts_t;

  localparam plcm_pts_t PTS_RESET = {
    40'd0, 40'd50331648590, 40'd33554432345, 40'd16777216155,
    40'd0, 40'd1082751188832, 40'd1065973972642, 40'd1049196756392
  };

  typedef struct packed {
    logic             vld;
    logic             mode;
    logic             ok;
    logic             neg;
    logic [POS_W-1:0] v0;
    logic [QBITS-1:0] w;
    logic [QBITS-1:0] rem;
    logic [QBITS-1:0] num;
    logic [QBITS-1:0] quo;
  } plcm_div_t;

endpackage

// ----- rtl/core/plcm_front.sv -----
module plcm_front #(
  parameter int NUM_POINTS = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic                          mode,
  input  logic [plcm_pkg::ANG_W-1:0]    angle,
  input  logic [plcm_pkg::POS_W-1:0]    position,
  input  plcm_pkg::plcm_pts_t           pts,
  output plcm_pkg::plcm_div_t           pkt
);

  localparam int LAST = NUM_POINTS - 1;

  logic signed [plcm_pkg::POS_W-1:0] k [NUM_POINTS];
  logic signed [plcm_pkg::POS_W-1:0] v [NUM_POINTS];
  logic signed [plcm_pkg::POS_W-1:0] x, kk0, kk1, vv0, vv1;
  logic                              found, inspan;
  logic signed [plcm_pkg::QBITS:0]   span;
  logic [plcm_pkg::QBITS-1:0]        d_nxt, w_nxt, mag_nxt;
  logic [plcm_pkg::POS_W-1:0]        v0_nxt;
  logic                              ok_nxt;

  logic                              s1_vld_r, s1_mode_r, s1_ok_r, s1_neg_r;
  logic [plcm_pkg::POS_W-1:0]        s1_v0_r;
  logic [plcm_pkg::QBITS-1:0]        s1_d_r, s1_w_r, s1_mag_r;
  logic [2*plcm_pkg::QBITS-1:0]      prod;
  plcm_pkg::plcm_div_t               pkt_r, pkt_nxt;

  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      if (mode) begin
        k[i] = pts[i][plcm_pkg::POS_W-1:0];
        v[i] = {{(plcm_pkg::POS_W-plcm_pkg::ANG_W){pts[i][plcm_pkg::PT_W-1]}},
                pts[i][plcm_pkg::PT_W-1:plcm_pkg::POS_W]};
      end else begin
        k[i] = {{(plcm_pkg::POS_W-plcm_pkg::ANG_W){pts[i][plcm_pkg::PT_W-1]}},
                pts[i][plcm_pkg::PT_W-1:plcm_pkg::POS_W]};
        v[i] = pts[i][plcm_pkg::POS_W-1:0];
      end
    end
    x = mode ? position :
        {{(plcm_pkg::POS_W-plcm_pkg::ANG_W){angle[plcm_pkg::ANG_W-1]}}, angle};
    found = 1'b0;
    kk0 = k[0];
    kk1 = k[0];
    vv0 = v[0];
    vv1 = v[0];
    for (int i = NUM_POINTS - 2; i >= 0; i--) begin
      if (x >= k[i] && x <= k[i+1]) begin
        found = 1'b1;
        kk0 = k[i];
        kk1 = k[i+1];
        vv0 = v[i];
        vv1 = v[i+1];
      end
    end
    inspan = (x >= k[0]) && (x <= k[LAST]);
    ok_nxt = inspan && (found || x == k[0] || x == k[LAST]);
    span = {{2{vv1[plcm_pkg::POS_W-1]}}, vv1} - {{2{vv0[plcm_pkg::POS_W-1]}}, vv0};
    mag_nxt = span[plcm_pkg::QBITS] ? plcm_pkg::QBITS'(-span) : span[plcm_pkg::QBITS-1:0];
    d_nxt = {x[plcm_pkg::POS_W-1], x} - {kk0[plcm_pkg::POS_W-1], kk0};
    w_nxt = {kk1[plcm_pkg::POS_W-1], kk1} - {kk0[plcm_pkg::POS_W-1], kk0};
    v0_nxt = vv0;
    priority if (x == k[0]) begin
      v0_nxt = v[0];
      d_nxt = '0;
      w_nxt = plcm_pkg::QBITS'(1);
    end else if (x == k[LAST]) begin
      v0_nxt = v[LAST];
      d_nxt = '0;
      w_nxt = plcm_pkg::QBITS'(1);
    end else if (w_nxt == '0) begin
      d_nxt = '0;
      w_nxt = plcm_pkg::QBITS'(1);
    end else begin
      v0_nxt = vv0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_vld;
      s1_mode_r <= mode;
      s1_ok_r   <= ok_nxt;
      s1_neg_r  <= span[plcm_pkg::QBITS];
      s1_v0_r   <= v0_nxt;
      s1_d_r    <= d_nxt;
      s1_w_r    <= w_nxt;
      s1_mag_r  <= mag_nxt;
    end
  end

  always_comb begin
    prod = s1_d_r * s1_mag_r;
    pkt_nxt.vld  = s1_vld_r;
    pkt_nxt.mode = s1_mode_r;
    pkt_nxt.ok   = s1_ok_r;
    pkt_nxt.neg  = s1_neg_r;
    pkt_nxt.v0   = s1_v0_r;
    pkt_nxt.w    = s1_w_r;
    pkt_nxt.rem  = prod[2*plcm_pkg::QBITS-1:plcm_pkg::QBITS];
    pkt_nxt.num  = prod[plcm_pkg::QBITS-1:0];
    pkt_nxt.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r.vld <= 1'b0;
    end else if (en) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign pkt = pkt_r;

endmodule

// ----- rtl/core/plcm_div_cell.sv -----
module plcm_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  plcm_pkg::plcm_div_t pkt_in,
  output plcm_pkg::plcm_div_t pkt_out
);

  logic [plcm_pkg::QBITS:0] trial, diff;
  plcm_pkg::plcm_div_t      pkt_r, pkt_nxt;

  always_comb begin
    pkt_nxt = pkt_in;
    trial = {pkt_in.rem, pkt_in.num[plcm_pkg::QBITS-1]};
    diff = trial - {1'b0, pkt_in.w};
    pkt_nxt.num = {pkt_in.num[plcm_pkg::QBITS-2:0], 1'b0};
    if (!diff[plcm_pkg::QBITS]) begin
      pkt_nxt.rem = diff[plcm_pkg::QBITS-1:0];
      pkt_nxt.quo = {pkt_in.quo[plcm_pkg::QBITS-2:0], 1'b1};
    end else begin
      pkt_nxt.rem = trial[plcm_pkg::QBITS-1:0];
      pkt_nxt.quo = {pkt_in.quo[plcm_pkg::QBITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r.vld <= 1'b0;
    end else if (en) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign pkt_out = pkt_r;

endmodule

// ----- rtl/core/piecewise_linear_calibration_map.sv -----
// Channel   Direction  Handshake          Payload
// in_       request    in_valid/in_stall  in_mode, in_angle_in, in_position_in
// out_      result     out_valid/out_stall out_ok, out_position_out, out_angle_out
// cfg_      write      cfg_wr_en          cfg_index, cfg_data
// One request is taken every cycle unless in_stall is high; each result passes
// through the segment stage, the multiply stage, one divider cell per quotient bit
// and the output register. Reset restores the default table and empties the pipe.
// A stalled result freezes the whole pipe, and in_stall follows it.
module piecewise_linear_calibration_map #(
  parameter int NUM_POINTS = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic signed [15:0]            in_angle_in,
  input  logic signed [23:0]            in_position_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic signed [23:0]            out_position_out,
  output logic signed [15:0]            out_angle_out,
  input  logic                          cfg_wr_en,
  input  logic [plcm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [plcm_pkg::PT_W-1:0]     cfg_data
);

  plcm_pkg::plcm_pts_t pts_r;
  plcm_pkg::plcm_div_t chain [plcm_pkg::QBITS+1];
  logic                en;
  logic                out_valid_r, out_ok_r;
  logic [23:0]         out_pos_r;
  logic [15:0]         out_ang_r;
  logic [plcm_pkg::QBITS:0] q;
  logic [plcm_pkg::QBITS:0] res;
  plcm_pkg::plcm_div_t last;

  assign en = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r <= plcm_pkg::PTS_RESET;
    end else if (cfg_wr_en && 32'(cfg_index) < plcm_pkg::CFG_REGS &&
                 32'(cfg_index) < NUM_POINTS) begin
      pts_r[cfg_index] <= cfg_data;
    end
  end

  plcm_front #(.NUM_POINTS(NUM_POINTS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .mode     (in_mode),
    .angle    (in_angle_in),
    .position (in_position_in),
    .pts      (pts_r),
    .pkt      (chain[0])
  );

  for (genvar g = 0; g < plcm_pkg::QBITS; g++) begin : g_cell
    plcm_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .pkt_in  (chain[g]),
      .pkt_out (chain[g+1])
    );
  end

  always_comb begin
    last = chain[plcm_pkg::QBITS];
    q = last.neg ? -{1'b0, last.quo} : {1'b0, last.quo};
    res = {{2{last.v0[23]}}, last.v0} + q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.vld;
      out_ok_r    <= last.ok;
      out_pos_r   <= (last.ok && !last.mode) ? res[23:0] : '0;
      out_ang_r   <= (last.ok && last.mode) ? res[15:0] : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_position_out = out_pos_r;
  assign out_angle_out    = out_ang_r;

endmodule

// ----- rtl/core/plcm_checker.sv -----
module plcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_ok,
  input logic [23:0] out_position_out,
  input logic [15:0] out_angle_out
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_position_out) &&
    $stable(out_angle_out) && $stable(out_ok))
    else $error("stalled result changed");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without a stalled result");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_position_out == 24'd0 && out_angle_out == 16'd0)
    else $error("rejected request carries data");

  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position_out == 24'd0 || out_angle_out == 16'd0)
    else $error("both result fields set");

endmodule

bind piecewise_linear_calibration_map plcm_checker u_plcm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_ok           (out_ok),
  .out_position_out (out_position_out),
  .out_angle_out    (out_angle_out)
);
